/* hdl/ramb_pkg.sv */
// ----------------------------------------------------------------------------
// ramb_pkg
// Shared types and constants for the region attention mask builder: command
// codes, register indexes, transaction payloads and configuration bundle.
// ----------------------------------------------------------------------------
package ramb_pkg;

	localparam int INDEX_W    = 11;
	localparam int REGION_W   = 8;
	localparam int MASK_W     = 16;
	localparam int POOL_CNT_W = 7;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam int DEF_MAX_POOL   = 64;
	localparam int DEF_MAX_FRAMES = 1024;

	localparam logic [MASK_W-1:0] BLOCKED_RESET = 16'hF0E2;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_POOL_COUNT = 1'b0,
		REG_BLOCKED    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t                        cmd;
		logic signed [REGION_W-1:0]  region_id;
		logic [INDEX_W-1:0]          query_index;
		logic [INDEX_W-1:0]          key_index;
	} req_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask_value;
		logic              allowed;
		logic              in_range;
	} rsp_t;

	typedef struct packed {
		logic [POOL_CNT_W-1:0] pool_count;
		logic [MASK_W-1:0]     blocked_value;
	} cfg_t;

endpackage

/* hdl/ramb_cfg.sv */
// ----------------------------------------------------------------------------
// ramb_cfg
// APB register file: pool count (saturating at the pool capacity) and the
// fp16 word returned for blocked pairs.
// ----------------------------------------------------------------------------
module ramb_cfg #(
	parameter int MAX_POOL = ramb_pkg::DEF_MAX_POOL
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ramb_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ramb_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ramb_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output ramb_pkg::cfg_t                    cfg
);
	import ramb_pkg::*;

	localparam int POOL_SAT_I = (MAX_POOL > 127) ? 127 : MAX_POOL;
	localparam logic [POOL_CNT_W-1:0] POOL_SAT = POOL_CNT_W'(POOL_SAT_I);

	logic [POOL_CNT_W-1:0] pool_count_q;
	logic [MASK_W-1:0]     blocked_q;
	logic                  wr_en;
	reg_idx_t              reg_idx;
	logic [POOL_CNT_W-1:0] pool_wr;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[2]);
	// clamp to the pool capacity
	assign pool_wr = (int'(pwdata[POOL_CNT_W-1:0]) > MAX_POOL) ? POOL_SAT
		: pwdata[POOL_CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_count_q <= '0;
			blocked_q    <= BLOCKED_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_POOL_COUNT: pool_count_q <= pool_wr;
				REG_BLOCKED:    blocked_q    <= pwdata[MASK_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_POOL_COUNT: prdata = APB_DATA_W'(pool_count_q);
			REG_BLOCKED:    prdata = APB_DATA_W'(blocked_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.pool_count    = pool_count_q;
	assign cfg.blocked_value = blocked_q;

endmodule

/* hdl/region_attention_mask_builder_core.sv */
// ----------------------------------------------------------------------------
// region_attention_mask_builder_core
// Joint-attention mask over pool tokens followed by frames, answered one
// element per query transaction from region tables held in block memories.
// ----------------------------------------------------------------------------
// Timing: a query's result strobe (done) is registered behind the stage-1 read
//   registers and stays high one cycle (memory read, then decide).
// Throughput: one transaction per cycle; busy stays low, since loads write the
//   memories at the accept edge, before any following query reads them.
// Reset: clears frame count and run valid bits, pool_count to 0, blocked word
//   to 0xF0E2; frame ids are undefined until loaded. The receiver cannot stall.
module region_attention_mask_builder_core #(
	parameter int MAX_POOL   = ramb_pkg::DEF_MAX_POOL,
	parameter int MAX_FRAMES = ramb_pkg::DEF_MAX_FRAMES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  ramb_pkg::req_t                    req,
	output logic                              done,
	output ramb_pkg::rsp_t                    rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ramb_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ramb_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ramb_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import ramb_pkg::*;

	// frame count holds 0..MAX_FRAMES; run bounds use the same width
	localparam int FCW   = $clog2(MAX_FRAMES + 1);
	localparam int FAW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int PAW   = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
	localparam int SUM_W = ((FCW > INDEX_W) ? FCW : INDEX_W) + 1;

	cfg_t cfg;

	ramb_cfg #(
		.MAX_POOL (MAX_POOL)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Storage: frame ids (two read ports), run first / past-last bounds
	// (one read port each), and a valid flop per region slot.
	// ------------------------------------------------------------------
	logic [REGION_W-1:0] regions_mem   [MAX_FRAMES];
	logic [FCW-1:0]      run_first_mem [MAX_POOL];
	logic [FCW-1:0]      run_past_mem  [MAX_POOL];
	logic [MAX_POOL-1:0] run_valid_q;
	logic [FCW-1:0]      frame_count_q;

	logic accept;
	logic is_load;
	logic is_clear;
	logic is_query;
	logic load_ok;
	logic run_hit;
	logic [REGION_W-1:0] rid_u;
	logic [PAW-1:0]      load_slot;
	logic [FAW-1:0]      load_addr;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_clear = accept && (req.cmd == CMD_CLEAR);
	assign is_load  = accept && (req.cmd == CMD_LOAD);
	assign is_query = accept && (req.cmd == CMD_QUERY);

	// drop loads once the frame table is full
	assign load_ok   = is_load && (frame_count_q != FCW'(MAX_FRAMES));
	assign load_addr = frame_count_q[FAW-1:0];
	assign rid_u     = req.region_id;
	// runs are tracked for any id 1..MAX_POOL, judged against N later
	assign run_hit   = !rid_u[REGION_W-1] && (rid_u != '0) && (int'(rid_u) <= MAX_POOL);
	assign load_slot = PAW'(rid_u - REGION_W'(1));

	always_ff @(posedge clk) begin
		if (load_ok) begin
			regions_mem[load_addr] <= req.region_id;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && run_hit) begin
			if (!run_valid_q[load_slot]) begin
				run_first_mem[load_slot] <= frame_count_q;
			end
			run_past_mem[load_slot] <= frame_count_q + FCW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q   <= '0;
			frame_count_q <= '0;
		end else begin
			if (is_clear) begin
				run_valid_q   <= '0;
				frame_count_q <= '0;
			end else if (load_ok) begin
				if (run_hit) begin
					run_valid_q[load_slot] <= 1'b1;
				end
				frame_count_q <= frame_count_q + FCW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: read frame ids of the query and key frames and the run
	// bounds of the slot the pool query names.
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] q_ext;
	logic [SUM_W-1:0] k_ext;
	logic [SUM_W-1:0] n_ext;
	logic [SUM_W-1:0] q_diff;
	logic [SUM_W-1:0] k_diff;
	logic [FAW-1:0]   q_faddr;
	logic [FAW-1:0]   k_faddr;
	logic [PAW-1:0]   q_slot;

	assign q_ext   = SUM_W'(req.query_index);
	assign k_ext   = SUM_W'(req.key_index);
	assign n_ext   = SUM_W'(cfg.pool_count);
	assign q_diff  = q_ext - n_ext;
	assign k_diff  = k_ext - n_ext;
	assign q_faddr = q_diff[FAW-1:0];
	assign k_faddr = k_diff[FAW-1:0];
	assign q_slot  = req.query_index[PAW-1:0];

	logic [REGION_W-1:0] rq_s1;
	logic [REGION_W-1:0] rk_s1;
	logic [FCW-1:0]      first_s1;
	logic [FCW-1:0]      past_s1;
	logic                run_valid_s1;
	logic [INDEX_W-1:0]  q_s1;
	logic [INDEX_W-1:0]  k_s1;
	logic [FCW-1:0]      fc_s1;
	logic                valid_s1;

	always_ff @(posedge clk) begin
		if (is_query) begin
			rq_s1    <= regions_mem[q_faddr];
			rk_s1    <= regions_mem[k_faddr];
			first_s1 <= run_first_mem[q_slot];
			past_s1  <= run_past_mem[q_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			run_valid_s1 <= run_valid_q[q_slot];
			q_s1         <= req.query_index;
			k_s1         <= req.key_index;
			fc_s1        <= frame_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= is_query;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: decide and register the result transaction.
	// ------------------------------------------------------------------
	function automatic logic id_ok(input logic [REGION_W-1:0] r,
			input logic [POOL_CNT_W-1:0] n);
		return !r[REGION_W-1] && (r != '0) && (r[POOL_CNT_W-1:0] <= n);
	endfunction

	logic [SUM_W-1:0] q2;
	logic [SUM_W-1:0] k2;
	logic [SUM_W-1:0] n2;
	logic [SUM_W-1:0] span;
	logic [SUM_W-1:0] kx;
	logic             in_rng;
	logic             q_pool;
	logic             k_pool;
	logic             pool_ok;
	logic             frame_ok;
	logic             ok;

	assign q2     = SUM_W'(q_s1);
	assign k2     = SUM_W'(k_s1);
	assign n2     = SUM_W'(cfg.pool_count);
	assign span   = n2 + SUM_W'(fc_s1);
	assign kx     = k2 - n2;
	assign in_rng = (q2 < span) && (k2 < span);
	assign q_pool = q2 < n2;
	assign k_pool = k2 < n2;

	// pool query: all pool keys, plus frame keys inside the region's run
	assign pool_ok = k_pool || (run_valid_s1 && (kx >= SUM_W'(first_s1))
		&& (kx < SUM_W'(past_s1)));

	// frame query: its own pool token, and every frame key with a valid id
	assign frame_ok = id_ok(rq_s1, cfg.pool_count) && (k_pool
		? (k2 == SUM_W'(rq_s1[POOL_CNT_W-1:0] - POOL_CNT_W'(1)))
		: id_ok(rk_s1, cfg.pool_count));

	assign ok = in_rng && (q_pool ? pool_ok : frame_ok);

	rsp_t rsp_q;
	logic done_q;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.mask_value <= ok ? '0 : cfg.blocked_value;
			rsp_q.allowed    <= ok;
			rsp_q.in_range   <= in_rng;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
